FILE: hdl/pptb_pkg.sv
// Package with the item types, operation codes and constants of the periodic timer bank.
package pptb_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_INIT = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    localparam logic [15:0] STOPPED_COUNT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  timer_index;
        logic [15:0] period;
        logic [15:0] first_count;
    } cmd_t;

    typedef struct packed {
        logic       expired_valid;
        logic [4:0] expired_index;
        logic       init_rejected;
    } rsp_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] period;
    } timer_entry_t;

endpackage

FILE: hdl/polled_periodic_timer_bank.sv
// Top level of the periodic timer bank: a ring of timer cells and the sequencer at its head.
//
//   channel   direction  handshake            payload
//   command   in         start / busy         cmd (pptb_pkg::cmd_t)
//   response  out        done, one cycle      rsp (pptb_pkg::rsp_t)
//
// Every beat rotates the ring once, one timer per cycle through the update logic at cell 0,
// and busy stays high until the last timer has passed through that logic.
// The response shows for one cycle right after busy falls, and start is taken in that cycle.
// Reset stops every timer and clears every period at once.
// The receiver cannot stall the response.
module polled_periodic_timer_bank
#(
    parameter int NUM_TIMERS = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pptb_pkg::cmd_t cmd,
    output logic           done,
    output pptb_pkg::rsp_t rsp
);

    localparam int STEP_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CMP_W  = (STEP_W > 5) ? STEP_W : 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TIMERS - 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                 state_reg;
    pptb_pkg::cmd_t         cmd_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   found_reg;
    logic [4:0]             found_idx_reg;
    logic                   busy_reg;
    logic                   done_reg;
    pptb_pkg::rsp_t         rsp_reg;

    pptb_pkg::timer_entry_t entries [NUM_TIMERS];
    pptb_pkg::timer_entry_t head_next;
    logic                   shift;
    logic                   hit;
    logic                   running;
    logic                   idx_match;

    assign shift = (state_reg == S_WALK);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            if (gi == NUM_TIMERS - 1)
            begin : g_tail
                pptb_cell u_cell
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .entry_in  (head_next),
                    .entry_out (entries[gi])
                );
            end
            else
            begin : g_body
                pptb_cell u_cell
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .entry_in  (entries[gi+1]),
                    .entry_out (entries[gi])
                );
            end
        end
    endgenerate

    // Cell 0 holds the timer numbered by step_reg; its updated entry goes to the tail.
    always_comb
    begin
        head_next = entries[0];
        hit       = 1'b0;
        running   = (entries[0].count != pptb_pkg::STOPPED_COUNT);
        idx_match = (CMP_W'(cmd_reg.timer_index) == CMP_W'(step_reg));
        case (cmd_reg.operation)
            pptb_pkg::OP_TICK:
            begin
                if (running)
                begin
                    if (!found_reg && (entries[0].count >= entries[0].period))
                    begin
                        hit             = 1'b1;
                        head_next.count = 16'd1;
                    end
                    else
                    begin
                        head_next.count = entries[0].count + 16'd1;
                    end
                end
            end
            pptb_pkg::OP_INIT:
            begin
                if (idx_match && (cmd_reg.period != 16'd0))
                begin
                    head_next.count  = cmd_reg.first_count;
                    head_next.period = cmd_reg.period;
                end
            end
            pptb_pkg::OP_STOP:
            begin
                if (idx_match)
                begin
                    head_next.count = pptb_pkg::STOPPED_COUNT;
                end
            end
            default:
            begin
                head_next = entries[0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= 5'd0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
            cmd_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        busy_reg  <= 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (hit)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= 5'(step_reg);
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg             <= S_IDLE;
                        busy_reg              <= 1'b0;
                        done_reg              <= 1'b1;
                        rsp_reg.expired_valid <= hit || found_reg;
                        rsp_reg.expired_index <= hit ? 5'(step_reg)
                                               : (found_reg ? found_idx_reg : 5'd0);
                        rsp_reg.init_rejected <= (cmd_reg.operation == pptb_pkg::OP_INIT)
                                               && (cmd_reg.period == 16'd0);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: hdl/pptb_cell.sv
// One timer cell of the rotating chain: holds a count and a period and takes its neighbor's entry.
module pptb_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  pptb_pkg::timer_entry_t entry_in,
    output pptb_pkg::timer_entry_t entry_out
);

    pptb_pkg::timer_entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.count  <= pptb_pkg::STOPPED_COUNT;
            entry_reg.period <= 16'd0;
        end
        else if (shift)
        begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

FILE: hdl/pptb_checker.sv
// Port checker for the periodic timer bank and the bind that attaches it.
module pptb_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input pptb_pkg::rsp_t rsp
);

    // An accepted beat always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted beat");

    // A response appears exactly when busy has just fallen.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("response without the end of a busy period");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy period ended without a response");

    // A tick response and a rejected init never mix, and a missing expiry reads as zero.
    a_rsp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.expired_valid |-> rsp.expired_index == 5'd0)
        else $error("expired index set without an expiry");

    a_rsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.init_rejected |-> !rsp.expired_valid)
        else $error("rejected init reported an expiry");

endmodule

bind polled_periodic_timer_bank pptb_checker u_pptb_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
